### rtl/core/box_overlap_suppression_core_assert.svh
// Assertion macros for the box overlap suppression core
`ifndef BOX_OVERLAP_SUPPRESSION_CORE_ASSERT_SVH
`define BOX_OVERLAP_SUPPRESSION_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define BOS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define BOS_ASSERT_NEXT(lbl, cond, nxt, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (nxt)) else $error(msg);
`else
`define BOS_ASSERT(lbl, prop, msg)
`define BOS_ASSERT_NEXT(lbl, cond, nxt, msg)
`endif
`endif

### rtl/core/bos_pkg.sv
// Shared constants and types for the box overlap suppression core
`timescale 1ns / 1ps
package bos_pkg;

  localparam int FRAC_W      = 17;
  localparam int SCORE_W     = 17;
  localparam int DIM_W       = 13;
  localparam int OUT_COORD_W = 13;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int FRAC_SHIFT  = 16;

  localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);

  localparam int MAX_KEPT_DEF   = 32;
  localparam int COORD_BITS_DEF = 13;

  localparam logic [SCORE_W-1:0] SCORE_THR_RST   = SCORE_W'(52429);
  localparam logic [SCORE_W-1:0] OVERLAP_THR_RST = SCORE_W'(13107);
  localparam logic [DIM_W-1:0]   IMG_W_RST       = DIM_W'(640);
  localparam logic [DIM_W-1:0]   IMG_H_RST       = DIM_W'(480);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SCORE_THR   = 3'd0,
    REG_OVERLAP_THR = 3'd1,
    REG_IMG_WIDTH   = 3'd2,
    REG_IMG_HEIGHT  = 3'd3
  } cfg_reg_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } ovl_res_t;

endpackage

### rtl/core/bos_ifs.sv
// Valid/ready channel interfaces for detector boxes and kept results
`timescale 1ns / 1ps
interface bos_box_if;
  logic                         valid;
  logic                         ready;
  logic [bos_pkg::FRAC_W-1:0]   top_frac;
  logic [bos_pkg::FRAC_W-1:0]   left_frac;
  logic [bos_pkg::FRAC_W-1:0]   bottom_frac;
  logic [bos_pkg::FRAC_W-1:0]   right_frac;
  logic [bos_pkg::SCORE_W-1:0]  box_score;
  logic                         last_box;

  modport source (
    output valid, top_frac, left_frac, bottom_frac, right_frac, box_score, last_box,
    input  ready
  );
  modport sink (
    input  valid, top_frac, left_frac, bottom_frac, right_frac, box_score, last_box,
    output ready
  );
endinterface

interface bos_result_if;
  logic                             valid;
  logic                             ready;
  logic [bos_pkg::OUT_COORD_W-1:0]  out_left;
  logic [bos_pkg::OUT_COORD_W-1:0]  out_top;
  logic [bos_pkg::OUT_COORD_W-1:0]  out_right;
  logic [bos_pkg::OUT_COORD_W-1:0]  out_bottom;
  logic [bos_pkg::SCORE_W-1:0]      out_score;
  logic                             no_boxes;
  logic                             table_overflowed;
  logic                             last_result;

  modport source (
    output valid, out_left, out_top, out_right, out_bottom, out_score, no_boxes,
           table_overflowed, last_result,
    input  ready
  );
  modport sink (
    input  valid, out_left, out_top, out_right, out_bottom, out_score, no_boxes,
           table_overflowed, last_result,
    output ready
  );
endinterface

### rtl/core/bos_table.sv
// Kept box table: one write port, one registered read port
`timescale 1ns / 1ps
module bos_table #(
  parameter int DEPTH = bos_pkg::MAX_KEPT_DEF,
  parameter int AW    = 5,
  parameter int DW    = 69
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/bos_overlap.sv
// Pipelined overlap test of the new box against one kept box per cycle
`timescale 1ns / 1ps
module bos_overlap #(
  parameter int CW    = bos_pkg::COORD_BITS_DEF,
  parameter int IDX_W = 5
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic [IDX_W-1:0]             in_idx,
  input  logic [CW-1:0]                nl,
  input  logic [CW-1:0]                nt,
  input  logic [CW-1:0]                nr,
  input  logic [CW-1:0]                nb,
  input  logic [CW-1:0]                kl,
  input  logic [CW-1:0]                kt,
  input  logic [CW-1:0]                kr,
  input  logic [CW-1:0]                kb,
  input  logic [bos_pkg::SCORE_W-1:0]  kscore,
  input  logic [bos_pkg::SCORE_W-1:0]  thr,
  output bos_pkg::ovl_res_t            res,
  output logic [IDX_W-1:0]             res_idx,
  output logic [bos_pkg::SCORE_W-1:0]  res_score
);

  localparam int AW = 2 * CW;
  localparam int PW = AW + bos_pkg::SCORE_W;

  logic [CW-1:0] il, it, ir, ib;
  logic [CW-1:0] iw_c, ih_c, uw_c, uh_c;
  logic          n_empty, k_empty;

  logic                        s1_valid, s2_valid, s3_valid, s4_valid;
  logic [IDX_W-1:0]            s1_idx, s2_idx, s3_idx, s4_idx;
  logic [bos_pkg::SCORE_W-1:0] s1_score, s2_score, s3_score, s4_score;
  logic [CW-1:0]               s1_iw, s1_ih, s1_uw, s1_uh;
  logic [AW-1:0]               s2_inter, s2_uni, s3_inter;
  logic [PW-1:0]               s3_prod;
  logic                        s4_hit;
  logic [PW-1:0]               inter_q16;

  always_comb begin
    il = (nl > kl) ? nl : kl;
    it = (nt > kt) ? nt : kt;
    ir = (nr < kr) ? nr : kr;
    ib = (nb < kb) ? nb : kb;
    iw_c = (ir > il) ? ir - il : '0;
    ih_c = (ib > it) ? ib - it : '0;
    n_empty = (nr <= nl) || (nb <= nt);
    k_empty = (kr <= kl) || (kb <= kt);
    priority if (n_empty && k_empty) begin
      uw_c = '0;
      uh_c = '0;
    end else if (n_empty) begin
      uw_c = kr - kl;
      uh_c = kb - kt;
    end else if (k_empty) begin
      uw_c = nr - nl;
      uh_c = nb - nt;
    end else begin
      uw_c = ((nr > kr) ? nr : kr) - ((nl < kl) ? nl : kl);
      uh_c = ((nb > kb) ? nb : kb) - ((nt < kt) ? nt : kt);
    end
  end

  assign inter_q16 = {s3_inter, {bos_pkg::FRAC_SHIFT{1'b0}}, 1'b0} >> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= in_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
    s1_idx   <= in_idx;
    s1_score <= kscore;
    s1_iw    <= iw_c;
    s1_ih    <= ih_c;
    s1_uw    <= uw_c;
    s1_uh    <= uh_c;
    s2_idx   <= s1_idx;
    s2_score <= s1_score;
    s2_inter <= AW'(s1_iw) * AW'(s1_ih);
    s2_uni   <= AW'(s1_uw) * AW'(s1_uh);
    s3_idx   <= s2_idx;
    s3_score <= s2_score;
    s3_inter <= s2_inter;
    s3_prod  <= PW'(thr) * PW'(s2_uni);
    s4_idx   <= s3_idx;
    s4_score <= s3_score;
    s4_hit   <= inter_q16 >= s3_prod;
  end

  assign res.valid = s4_valid;
  assign res.hit   = s4_hit;
  assign res_idx   = s4_idx;
  assign res_score = s4_score;

endmodule

### rtl/core/box_overlap_suppression_core.sv
// Top level: box sequencer, scaling multiplier, kept table and overlap pipeline
// Sequence: a box below the score threshold that does not close a frame is dropped in IDLE;
//   a passing box runs the 4-step scale, the order step, the scan in which the overlap
//   pipeline takes one kept entry per cycle, and the append step.
// Flow: one box at a time; on the last box each kept result is read through the single
//   table read port in EMIT and loaded in EMIT_LOAD, an empty frame result straight in EMIT.
// Reset (rst, synchronous): config to defaults, kept count and overflow flag cleared;
//   table contents are left as they are.
`timescale 1ns / 1ps
`include "box_overlap_suppression_core_assert.svh"
module box_overlap_suppression_core #(
  parameter int MAX_KEPT   = bos_pkg::MAX_KEPT_DEF,
  parameter int COORD_BITS = bos_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [bos_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [bos_pkg::CFG_DATA_W-1:0]  cfg_data,
  bos_box_if.sink                         box_in,
  bos_result_if.source                    box_out
);

  localparam int CW      = COORD_BITS;
  localparam int IDX_W   = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int CNT_W   = $clog2(MAX_KEPT + 1);
  localparam int SW      = bos_pkg::SCORE_W;
  localparam int EW      = 4 * CW + SW;
  localparam int CMPW    = (CW > bos_pkg::DIM_W) ? CW : bos_pkg::DIM_W;
  localparam int PW      = bos_pkg::FRAC_W + CW;
  localparam int MAX_DIM = 1 << (CW - 1);
  localparam int OUT_W   = bos_pkg::OUT_COORD_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_ORDER,
    ST_SCAN,
    ST_APPEND,
    ST_EMIT,
    ST_EMIT_LOAD
  } state_t;

  function automatic logic [OUT_W-1:0] to_out(input logic [CW-1:0] c);
    logic [CW+OUT_W-1:0] e;
    e = (CW + OUT_W)'(c);
    return e[OUT_W-1:0];
  endfunction

  state_t state;
  logic [1:0] step;

  logic [SW-1:0]                score_thr, ovl_thr;
  logic [bos_pkg::DIM_W-1:0]    img_w, img_h;

  logic [bos_pkg::FRAC_W-1:0]   frac_top, frac_left, frac_bottom, frac_right;
  logic [SW-1:0]                score_q;
  logic                         last_q;
  logic [CW-1:0]                x1, y1, x2, y2;
  logic [CW-1:0]                nl, nt, nr, nb;

  logic [CNT_W-1:0]             kept_count, rd_cnt, res_cnt, em_cnt;
  logic                         overflow_seen, found;
  logic                         rd_valid;
  logic [IDX_W-1:0]             rd_tag;

  logic                         out_valid, out_no_boxes, out_ovf, out_last;
  logic [OUT_W-1:0]             out_l, out_t, out_r, out_b;
  logic [SW-1:0]                out_s;
  logic                         out_load;

  logic [bos_pkg::FRAC_W-1:0]   sel_frac, frac_c;
  logic [bos_pkg::DIM_W-1:0]    sel_dim;
  logic [CMPW-1:0]              dim_x, dim_c;
  logic [PW-1:0]                scale_prod;
  logic [CW-1:0]                scale_coord;

  logic                         rd_issue, emit_last;
  logic                         tbl_we;
  logic [IDX_W-1:0]             tbl_waddr, tbl_raddr;
  logic [EW-1:0]                tbl_wdata, tbl_rdata;
  logic [CW-1:0]                kl, kt, kr, kb;
  logic [SW-1:0]                ks;

  bos_pkg::ovl_res_t            ovl_res;
  logic [IDX_W-1:0]             res_idx;
  logic [SW-1:0]                res_score;

  // shared scaling multiplier, one coordinate per step
  always_comb begin
    unique case (step)
      2'd0: begin sel_frac = frac_left;   sel_dim = img_w; end
      2'd1: begin sel_frac = frac_top;    sel_dim = img_h; end
      2'd2: begin sel_frac = frac_right;  sel_dim = img_w; end
      default: begin sel_frac = frac_bottom; sel_dim = img_h; end
    endcase
    frac_c = (sel_frac > bos_pkg::ONE_Q16) ? bos_pkg::ONE_Q16 : sel_frac;
    dim_x  = CMPW'(sel_dim);
    dim_c  = (dim_x > CMPW'(MAX_DIM)) ? CMPW'(MAX_DIM) : dim_x;
    scale_prod  = PW'(frac_c) * PW'(dim_c[CW-1:0]);
    scale_coord = scale_prod[bos_pkg::FRAC_SHIFT +: CW];
  end

  assign rd_issue  = (state == ST_SCAN) && (rd_cnt < kept_count);
  assign emit_last = (em_cnt + CNT_W'(1)) == kept_count;
  assign tbl_raddr = (state == ST_EMIT) ? em_cnt[IDX_W-1:0] : rd_cnt[IDX_W-1:0];
  assign tbl_wdata = {nl, nt, nr, nb, score_q};
  assign out_load  = ((state == ST_EMIT) && (!out_valid || box_out.ready) &&
                      (kept_count == '0)) || (state == ST_EMIT_LOAD);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = res_idx;
    if ((state == ST_SCAN) && ovl_res.valid && ovl_res.hit && (score_q > res_score)) begin
      tbl_we = 1'b1;
    end else if ((state == ST_APPEND) && !found && (kept_count < CNT_W'(MAX_KEPT))) begin
      tbl_we    = 1'b1;
      tbl_waddr = kept_count[IDX_W-1:0];
    end
  end

  assign kl = tbl_rdata[EW-1 -: CW];
  assign kt = tbl_rdata[EW-1-CW -: CW];
  assign kr = tbl_rdata[EW-1-2*CW -: CW];
  assign kb = tbl_rdata[EW-1-3*CW -: CW];
  assign ks = tbl_rdata[SW-1:0];

  bos_table #(
    .DEPTH (MAX_KEPT),
    .AW    (IDX_W),
    .DW    (EW)
  ) u_table (
    .clk   (clk),
    .we    (tbl_we),
    .waddr (tbl_waddr),
    .wdata (tbl_wdata),
    .raddr (tbl_raddr),
    .rdata (tbl_rdata)
  );

  bos_overlap #(
    .CW    (CW),
    .IDX_W (IDX_W)
  ) u_overlap (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_valid),
    .in_idx    (rd_tag),
    .nl        (nl),
    .nt        (nt),
    .nr        (nr),
    .nb        (nb),
    .kl        (kl),
    .kt        (kt),
    .kr        (kr),
    .kb        (kb),
    .kscore    (ks),
    .thr       (ovl_thr),
    .res       (ovl_res),
    .res_idx   (res_idx),
    .res_score (res_score)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      step          <= 2'd0;
      score_thr     <= bos_pkg::SCORE_THR_RST;
      ovl_thr       <= bos_pkg::OVERLAP_THR_RST;
      img_w         <= bos_pkg::IMG_W_RST;
      img_h         <= bos_pkg::IMG_H_RST;
      kept_count    <= '0;
      overflow_seen <= 1'b0;
      found         <= 1'b0;
      rd_cnt        <= '0;
      res_cnt       <= '0;
      em_cnt        <= '0;
      rd_valid      <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      rd_valid <= rd_issue;
      rd_tag   <= rd_cnt[IDX_W-1:0];

      if (cfg_we) begin
        unique case (cfg_index)
          bos_pkg::REG_SCORE_THR:   score_thr <= cfg_data[SW-1:0];
          bos_pkg::REG_OVERLAP_THR: ovl_thr   <= cfg_data[SW-1:0];
          bos_pkg::REG_IMG_WIDTH:   img_w     <= cfg_data[bos_pkg::DIM_W-1:0];
          bos_pkg::REG_IMG_HEIGHT:  img_h     <= cfg_data[bos_pkg::DIM_W-1:0];
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (box_out.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        ST_IDLE: begin
          if (box_in.valid) begin
            frac_top    <= box_in.top_frac;
            frac_left   <= box_in.left_frac;
            frac_bottom <= box_in.bottom_frac;
            frac_right  <= box_in.right_frac;
            score_q     <= box_in.box_score;
            last_q      <= box_in.last_box;
            step        <= 2'd0;
            if (box_in.box_score >= score_thr) begin
              state <= ST_SCALE;
            end else if (box_in.last_box) begin
              state <= ST_EMIT;
            end
          end
        end
        ST_SCALE: begin
          step <= step + 2'd1;
          unique case (step)
            2'd0: x1 <= scale_coord;
            2'd1: y1 <= scale_coord;
            2'd2: x2 <= scale_coord;
            default: begin
              y2    <= scale_coord;
              state <= ST_ORDER;
            end
          endcase
        end
        ST_ORDER: begin
          nl      <= (x1 < x2) ? x1 : x2;
          nr      <= (x1 < x2) ? x2 : x1;
          nt      <= (y1 < y2) ? y1 : y2;
          nb      <= (y1 < y2) ? y2 : y1;
          rd_cnt  <= '0;
          res_cnt <= '0;
          found   <= 1'b0;
          state   <= ST_SCAN;
        end
        ST_SCAN: begin
          if (rd_issue) begin
            rd_cnt <= rd_cnt + CNT_W'(1);
          end
          if (ovl_res.valid) begin
            res_cnt <= res_cnt + CNT_W'(1);
            if (ovl_res.hit) begin
              found <= 1'b1;
            end
          end
          if (res_cnt == kept_count) begin
            state <= ST_APPEND;
          end
        end
        ST_APPEND: begin
          if (!found) begin
            if (kept_count < CNT_W'(MAX_KEPT)) begin
              kept_count <= kept_count + CNT_W'(1);
            end else begin
              overflow_seen <= 1'b1;
            end
          end
          state <= last_q ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (!out_valid || box_out.ready) begin
            if (kept_count == '0) begin
              out_l         <= '0;
              out_t         <= '0;
              out_r         <= '0;
              out_b         <= '0;
              out_s         <= '0;
              out_no_boxes  <= 1'b1;
              out_ovf       <= overflow_seen;
              out_last      <= 1'b1;
              overflow_seen <= 1'b0;
              state         <= ST_IDLE;
            end else begin
              state <= ST_EMIT_LOAD;
            end
          end
        end
        ST_EMIT_LOAD: begin
          out_l        <= to_out(kl);
          out_t        <= to_out(kt);
          out_r        <= to_out(kr);
          out_b        <= to_out(kb);
          out_s        <= ks;
          out_no_boxes <= 1'b0;
          out_ovf      <= overflow_seen;
          out_last     <= emit_last;
          if (emit_last) begin
            kept_count    <= '0;
            overflow_seen <= 1'b0;
            em_cnt        <= '0;
            state         <= ST_IDLE;
          end else begin
            em_cnt <= em_cnt + CNT_W'(1);
            state  <= ST_EMIT;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign box_in.ready              = (state == ST_IDLE) && !rst;
  assign box_out.valid             = out_valid;
  assign box_out.out_left          = out_l;
  assign box_out.out_top           = out_t;
  assign box_out.out_right         = out_r;
  assign box_out.out_bottom        = out_b;
  assign box_out.out_score         = out_s;
  assign box_out.no_boxes          = out_no_boxes;
  assign box_out.table_overflowed  = out_ovf;
  assign box_out.last_result       = out_last;

  `BOS_ASSERT(a_count_bound, kept_count <= CNT_W'(MAX_KEPT), "kept count above table depth")
  `BOS_ASSERT(a_res_in_scan, !ovl_res.valid || (state == ST_SCAN), "overlap word outside scan")
  `BOS_ASSERT(a_scan_order, (state != ST_SCAN) || (res_cnt <= rd_cnt), "more words back than read")
  `BOS_ASSERT_NEXT(a_clear_after_emit, (state == ST_EMIT_LOAD) && emit_last, (kept_count == '0) && !overflow_seen && (state == ST_IDLE), "table not cleared after frame")

endmodule

### tb/box_overlap_suppression_core_tb.sv
// Testbench for box_overlap_suppression_core: directed boxes and random frames vs a predictor
`timescale 1ns / 1ps
module box_overlap_suppression_core_tb;

  localparam int FRAC_W        = bos_pkg::FRAC_W;
  localparam int SCORE_W       = bos_pkg::SCORE_W;
  localparam int DIM_W         = bos_pkg::DIM_W;
  localparam int OUT_COORD_W   = bos_pkg::OUT_COORD_W;
  localparam int CFG_IDX_W     = bos_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W    = bos_pkg::CFG_DATA_W;
  localparam int KEPT_DEPTH    = bos_pkg::MAX_KEPT_DEF;
  localparam int MAX_DIM       = 1 << (bos_pkg::COORD_BITS_DEF - 1);
  localparam int SETTLE_CYCLES = KEPT_DEPTH + 16;
  localparam int CYCLE_LIMIT   = 3000000;

  typedef struct packed {
    logic [FRAC_W-1:0]  top_frac;
    logic [FRAC_W-1:0]  left_frac;
    logic [FRAC_W-1:0]  bottom_frac;
    logic [FRAC_W-1:0]  right_frac;
    logic [SCORE_W-1:0] box_score;
    logic               last_box;
  } box_word_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] left;
    logic [OUT_COORD_W-1:0] top;
    logic [OUT_COORD_W-1:0] right;
    logic [OUT_COORD_W-1:0] bottom;
    logic [SCORE_W-1:0]     score;
    logic                   no_boxes;
    logic                   overflowed;
    logic                   last_result;
  } kept_result_t;

  typedef struct packed {
    logic [OUT_COORD_W-1:0] l;
    logic [OUT_COORD_W-1:0] t;
    logic [OUT_COORD_W-1:0] r;
    logic [OUT_COORD_W-1:0] b;
  } pixel_box_t;

  typedef struct packed {
    box_word_t    box;
    logic         typed;
    kept_result_t want;
  } dir_row_t;

  typedef enum {FRAME_CLUSTER, FRAME_NOISE, FRAME_BROKEN, FRAME_CROWD} frame_kind_t;

  logic clk = 1'b0;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  bos_box_if    box_ch ();
  bos_result_if res_ch ();

  box_overlap_suppression_core u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .box_in    (box_ch),
    .box_out   (res_ch)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  logic [SCORE_W-1:0] mdl_score_thr   = bos_pkg::SCORE_THR_RST;
  logic [SCORE_W-1:0] mdl_overlap_thr = bos_pkg::OVERLAP_THR_RST;
  logic [DIM_W-1:0]   mdl_width       = bos_pkg::IMG_W_RST;
  logic [DIM_W-1:0]   mdl_height      = bos_pkg::IMG_H_RST;
  pixel_box_t         kept_boxes [KEPT_DEPTH];
  logic [SCORE_W-1:0] kept_scores [KEPT_DEPTH];
  int unsigned        kept_n        = 0;
  logic               kept_overflow = 1'b0;

  kept_result_t pending_kept [$];
  dir_row_t     directed_rows [$];

  int fail_count      = 0;
  int results_checked = 0;
  int boxes_sent      = 0;
  int frames_sent     = 0;
  int settings_used   = 1;
  int cycle_count     = 0;

  function automatic logic [OUT_COORD_W-1:0] frac_to_pixel(logic [FRAC_W-1:0] frac,
                                                            logic [DIM_W-1:0] dim);
    longint unsigned f, d;
    f = (frac > bos_pkg::ONE_Q16) ? bos_pkg::ONE_Q16 : frac;
    d = (dim > MAX_DIM) ? MAX_DIM : dim;
    return OUT_COORD_W'((f * d) >> bos_pkg::FRAC_SHIFT);
  endfunction

  function automatic bit box_is_empty(pixel_box_t a);
    return (a.r <= a.l) || (a.b <= a.t);
  endfunction

  function automatic longint unsigned box_area(pixel_box_t a);
    longint unsigned w, h;
    w = a.r - a.l;
    h = a.b - a.t;
    return w * h;
  endfunction

  function automatic bit boxes_overlap(pixel_box_t a, pixel_box_t b);
    pixel_box_t      isect, hull;
    longint unsigned inter, uni;
    isect.l = (a.l > b.l) ? a.l : b.l;
    isect.t = (a.t > b.t) ? a.t : b.t;
    isect.r = (a.r < b.r) ? a.r : b.r;
    isect.b = (a.b < b.b) ? a.b : b.b;
    inter = 0;
    if (isect.r > isect.l && isect.b > isect.t) inter = box_area(isect);
    if (box_is_empty(a)) begin
      uni = box_is_empty(b) ? 0 : box_area(b);
    end else if (box_is_empty(b)) begin
      uni = box_area(a);
    end else begin
      hull.l = (a.l < b.l) ? a.l : b.l;
      hull.t = (a.t < b.t) ? a.t : b.t;
      hull.r = (a.r > b.r) ? a.r : b.r;
      hull.b = (a.b > b.b) ? a.b : b.b;
      uni = box_area(hull);
    end
    return inter * 64'd65536 >= 64'(mdl_overlap_thr) * uni;
  endfunction

  task automatic suppress_box(input box_word_t w, output kept_result_t emitted[$]);
    logic [OUT_COORD_W-1:0] x1, y1, x2, y2;
    pixel_box_t             nb;
    bit                     hit;
    kept_result_t           res;
    emitted = {};
    if (w.box_score >= mdl_score_thr) begin
      x1 = frac_to_pixel(w.left_frac, mdl_width);
      y1 = frac_to_pixel(w.top_frac, mdl_height);
      x2 = frac_to_pixel(w.right_frac, mdl_width);
      y2 = frac_to_pixel(w.bottom_frac, mdl_height);
      nb.l = (x1 < x2) ? x1 : x2;
      nb.r = (x1 < x2) ? x2 : x1;
      nb.t = (y1 < y2) ? y1 : y2;
      nb.b = (y1 < y2) ? y2 : y1;
      hit = 1'b0;
      for (int j = 0; j < kept_n; j++) begin
        if (boxes_overlap(nb, kept_boxes[j])) begin
          hit = 1'b1;
          if (w.box_score > kept_scores[j]) begin
            kept_boxes[j]  = nb;
            kept_scores[j] = w.box_score;
          end
        end
      end
      if (!hit) begin
        if (kept_n < KEPT_DEPTH) begin
          kept_boxes[kept_n]  = nb;
          kept_scores[kept_n] = w.box_score;
          kept_n++;
        end else begin
          kept_overflow = 1'b1;
        end
      end
    end
    if (w.last_box) begin
      if (kept_n == 0) begin
        res             = '0;
        res.no_boxes    = 1'b1;
        res.overflowed  = kept_overflow;
        res.last_result = 1'b1;
        emitted = {emitted, res};
      end else begin
        for (int k = 0; k < kept_n; k++) begin
          res.left        = kept_boxes[k].l;
          res.top         = kept_boxes[k].t;
          res.right       = kept_boxes[k].r;
          res.bottom      = kept_boxes[k].b;
          res.score       = kept_scores[k];
          res.no_boxes    = 1'b0;
          res.overflowed  = kept_overflow;
          res.last_result = (k + 1 == kept_n);
          emitted = {emitted, res};
        end
      end
      kept_n        = 0;
      kept_overflow = 1'b0;
    end
  endtask

  function automatic box_word_t mk_box(int unsigned t, int unsigned l, int unsigned b,
                                       int unsigned r, int unsigned s, bit last);
    box_word_t w;
    w.top_frac    = FRAC_W'(t);
    w.left_frac   = FRAC_W'(l);
    w.bottom_frac = FRAC_W'(b);
    w.right_frac  = FRAC_W'(r);
    w.box_score   = SCORE_W'(s);
    w.last_box    = last;
    return w;
  endfunction

  function automatic kept_result_t mk_res(int unsigned l, int unsigned t, int unsigned r,
                                          int unsigned b, int unsigned s, bit nob, bit ovf,
                                          bit last);
    kept_result_t k;
    k.left        = OUT_COORD_W'(l);
    k.top         = OUT_COORD_W'(t);
    k.right       = OUT_COORD_W'(r);
    k.bottom      = OUT_COORD_W'(b);
    k.score       = SCORE_W'(s);
    k.no_boxes    = nob;
    k.overflowed  = ovf;
    k.last_result = last;
    return k;
  endfunction

  function automatic dir_row_t mk_row(box_word_t w, bit typed, kept_result_t want);
    dir_row_t row;
    row.box   = w;
    row.typed = typed;
    row.want  = want;
    return row;
  endfunction

  function automatic int pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 75) return 0;
    if (p < 95) return $urandom_range(1, 4);
    return $urandom_range(15, 60);
  endfunction

  function automatic logic [SCORE_W-1:0] pick_score();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 80 && mdl_score_thr <= bos_pkg::ONE_Q16)
      return SCORE_W'($urandom_range(mdl_score_thr, 65536));
    if (p < 90 && mdl_score_thr > 0) return SCORE_W'($urandom_range(0, mdl_score_thr - 1));
    return SCORE_W'($urandom_range(0, 131071));
  endfunction

  function automatic logic [FRAC_W-1:0] clamp_frac(int v);
    if (v < 0) return '0;
    if (v > 131071) return '1;
    return FRAC_W'(v);
  endfunction

  function automatic box_word_t cluster_box(int cx, int cy);
    box_word_t w;
    int hw, hh, x1, x2, y1, y2;
    hw = int'($urandom_range(200, 12000));
    hh = int'($urandom_range(200, 12000));
    x1 = cx - hw + int'($urandom_range(0, 3000)) - 1500;
    x2 = cx + hw + int'($urandom_range(0, 3000)) - 1500;
    y1 = cy - hh + int'($urandom_range(0, 3000)) - 1500;
    y2 = cy + hh + int'($urandom_range(0, 3000)) - 1500;
    if ($urandom_range(0, 19) == 0) x2 = x1;
    if ($urandom_range(0, 19) == 0) y2 = y1;
    if ($urandom_range(0, 2) == 0) begin
      w.left_frac  = clamp_frac(x2);
      w.right_frac = clamp_frac(x1);
    end else begin
      w.left_frac  = clamp_frac(x1);
      w.right_frac = clamp_frac(x2);
    end
    if ($urandom_range(0, 2) == 0) begin
      w.top_frac    = clamp_frac(y2);
      w.bottom_frac = clamp_frac(y1);
    end else begin
      w.top_frac    = clamp_frac(y1);
      w.bottom_frac = clamp_frac(y2);
    end
    w.box_score = '0;
    w.last_box  = 1'b0;
    return w;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endfunction

  task automatic send_box(box_word_t w, bit typed, kept_result_t want);
    kept_result_t fresh [$];
    int           gap;
    box_ch.valid       <= 1'b1;
    box_ch.top_frac    <= w.top_frac;
    box_ch.left_frac   <= w.left_frac;
    box_ch.bottom_frac <= w.bottom_frac;
    box_ch.right_frac  <= w.right_frac;
    box_ch.box_score   <= w.box_score;
    box_ch.last_box    <= w.last_box;
    do @(posedge clk); while (!box_ch.ready);
    suppress_box(w, fresh);
    if (typed) pending_kept = {pending_kept, want};
    else pending_kept = {pending_kept, fresh};
    boxes_sent++;
    if (w.last_box) frames_sent++;
    gap = pick_gap();
    // hold valid into the next word when no gap follows
    if (gap > 0) begin
      box_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    box_ch.valid <= 1'b0;
    while (pending_kept.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(bos_pkg::cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      bos_pkg::REG_SCORE_THR:   mdl_score_thr   = val[SCORE_W-1:0];
      bos_pkg::REG_OVERLAP_THR: mdl_overlap_thr = val[SCORE_W-1:0];
      bos_pkg::REG_IMG_WIDTH:   mdl_width       = val[DIM_W-1:0];
      bos_pkg::REG_IMG_HEIGHT:  mdl_height      = val[DIM_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(int unsigned s, int unsigned o, int unsigned w, int unsigned h);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    write_reg(bos_pkg::REG_SCORE_THR, CFG_DATA_W'(s));
    write_reg(bos_pkg::REG_OVERLAP_THR, CFG_DATA_W'(o));
    write_reg(bos_pkg::REG_IMG_WIDTH, CFG_DATA_W'(w));
    write_reg(bos_pkg::REG_IMG_HEIGHT, CFG_DATA_W'(h));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic run_frame(frame_kind_t kind);
    int        n, nc, c;
    int        cx [4];
    int        cy [4];
    box_word_t w;
    case (kind)
      FRAME_CLUSTER: n = $urandom_range(1, 8);
      FRAME_NOISE:   n = $urandom_range(1, 6);
      FRAME_BROKEN:  n = $urandom_range(1, 4);
      default:       n = $urandom_range(34, 40);
    endcase
    nc = $urandom_range(1, 4);
    for (int i = 0; i < 4; i++) begin
      cx[i] = int'($urandom_range(0, 65536));
      cy[i] = int'($urandom_range(0, 65536));
    end
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, nc - 1);
      case (kind)
        FRAME_CLUSTER: begin
          w = cluster_box(cx[c], cy[c]);
          w.box_score = pick_score();
        end
        FRAME_NOISE: begin
          w = mk_box($urandom_range(0, 131071), $urandom_range(0, 131071),
                     $urandom_range(0, 131071), $urandom_range(0, 131071),
                     $urandom_range(0, 131071), 1'b0);
        end
        FRAME_BROKEN: begin
          w = cluster_box(cx[c], cy[c]);
          w.box_score = (mdl_score_thr > 0) ? SCORE_W'($urandom_range(0, mdl_score_thr - 1))
                                            : pick_score();
        end
        default: begin
          w = mk_box($urandom_range(0, 65536), $urandom_range(0, 65536),
                     $urandom_range(0, 65536), $urandom_range(0, 65536), 0, 1'b0);
          w.box_score = pick_score();
        end
      endcase
      w.last_box = (i == n - 1);
      send_box(w, 1'b0, '0);
    end
  endtask

  task automatic run_phase(int unsigned s, int unsigned o, int unsigned w, int unsigned h,
                           bit crowd, int budget);
    int          start;
    int unsigned p;
    set_config(s, o, w, h);
    if (crowd) run_frame(FRAME_CROWD);
    start = boxes_sent;
    while (boxes_sent - start < budget) begin
      p = $urandom_range(0, 99);
      if (p < 65) run_frame(FRAME_CLUSTER);
      else if (p < 85) run_frame(FRAME_NOISE);
      else run_frame(FRAME_BROKEN);
      if ($urandom_range(0, 3) == 0) wait_drained();
    end
  endtask

  initial begin
    int unsigned p;
    int          hold;
    res_ch.ready <= 1'b0;
    hold = 0;
    forever begin
      @(posedge clk);
      if (hold == 0) begin
        p = $urandom_range(0, 99);
        if (p < 70) begin
          res_ch.ready <= 1'b1;
          hold = $urandom_range(1, 20);
        end else if (p < 95) begin
          res_ch.ready <= 1'b0;
          hold = $urandom_range(1, 3);
        end else begin
          res_ch.ready <= 1'b0;
          hold = $urandom_range(20, 80);
        end
      end else begin
        hold--;
      end
    end
  end

  always @(posedge clk) begin
    kept_result_t want;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (pending_kept.size() == 0) begin
        $error("kept box word arrived with nothing expected");
        fail_count++;
      end else begin
        want = pending_kept.pop_front();
        check_field("out_left", want.left, res_ch.out_left);
        check_field("out_top", want.top, res_ch.out_top);
        check_field("out_right", want.right, res_ch.out_right);
        check_field("out_bottom", want.bottom, res_ch.out_bottom);
        check_field("out_score", want.score, res_ch.out_score);
        check_field("no_boxes", want.no_boxes, res_ch.no_boxes);
        check_field("table_overflowed", want.overflowed, res_ch.table_overflowed);
        check_field("last_result", want.last_result, res_ch.last_result);
        results_checked++;
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("run exceeded %0d cycles", CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= bos_pkg::REG_SCORE_THR;
    cfg_data           <= '0;
    box_ch.valid       <= 1'b0;
    box_ch.top_frac    <= '0;
    box_ch.left_frac   <= '0;
    box_ch.bottom_frac <= '0;
    box_ch.right_frac  <= '0;
    box_ch.box_score   <= '0;
    box_ch.last_box    <= 1'b0;

    directed_rows = {
      mk_row(mk_box(0, 0, 0, 0, 52428, 1), 1'b1, mk_res(0, 0, 0, 0, 0, 1, 0, 1)),
      mk_row(mk_box(0, 0, 65536, 65536, 65536, 1), 1'b1,
             mk_res(0, 0, 640, 480, 65536, 0, 0, 1)),
      mk_row(mk_box(131071, 131071, 0, 0, 52429, 1), 1'b1,
             mk_res(0, 0, 640, 480, 52429, 0, 0, 1)),
      mk_row(mk_box(0, 0, 0, 0, 131071, 1), 1'b1, mk_res(0, 0, 0, 0, 131071, 0, 0, 1)),
      mk_row(mk_box(0, 0, 13654, 10240, 60000, 0), 1'b0, '0),
      mk_row(mk_box(0, 10240, 13654, 20480, 58000, 0), 1'b0, '0),
      mk_row(mk_box(0, 5120, 13654, 15360, 62000, 0), 1'b0, '0),
      mk_row(mk_box(0, 5120, 13654, 15360, 62000, 0), 1'b0, '0),
      mk_row(mk_box(0, 6000, 13654, 15360, 53000, 0), 1'b0, '0),
      mk_row(mk_box(20000, 30000, 40000, 30000, 55000, 0), 1'b0, '0),
      mk_row(mk_box(50000, 40000, 50000, 45000, 57000, 0), 1'b0, '0),
      mk_row(mk_box(1000, 1000, 2000, 2000, 100, 1), 1'b0, '0),
      mk_row(mk_box(60000, 60000, 65536, 65536, 65536, 0), 1'b0, '0),
      mk_row(mk_box(65536, 65536, 60000, 60000, 65535, 0), 1'b0, '0),
      mk_row(mk_box(100000, 70000, 131071, 90000, 0, 1), 1'b0, '0),
      mk_row(mk_box(30000, 30000, 40000, 40000, 0, 1), 1'b1, mk_res(0, 0, 0, 0, 0, 1, 0, 1)),
      mk_row(mk_box(0, 0, 6554, 6554, 65000, 0), 1'b0, '0),
      mk_row(mk_box(58982, 58982, 65536, 65536, 54000, 1), 1'b0, '0)
    };

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[i])
      send_box(directed_rows[i].box, directed_rows[i].typed, directed_rows[i].want);

    run_phase(0, 65536, 4096, 4096, 1'b1, 10);
    run_phase(65536, 0, 8191, 1, 1'b0, 10);
    run_phase($urandom_range(0, 65536), $urandom_range(0, 65536), 0, 0, 1'b0, 8);
    run_phase(1, 1, 1, 4096, 1'b0, 10);
    repeat (3)
      run_phase($urandom_range(20000, 65536), $urandom_range(0, 65536),
                $urandom_range(1, 4096), $urandom_range(1, 4096), 1'b0, 12);
    run_phase(bos_pkg::SCORE_THR_RST, bos_pkg::OVERLAP_THR_RST, bos_pkg::IMG_W_RST,
              bos_pkg::IMG_H_RST, 1'b0, 10);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Checked %0d kept box words from %0d boxes in %0d frames.",
             results_checked, boxes_sent, frames_sent);
    $display("Register settings run: %0d, with zero, full-scale and clamped image sizes.",
             settings_used);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
